// ----- design/rnsd_pkg.sv -----
// Shared types and constants of the radix-N short divider.
// Holds register map codes, reset values and default widths; no dependencies.
`default_nettype none

package rnsd_pkg;

  localparam int DATA_W           = 32;
  localparam int ADDR_W           = 4;
  localparam int COUNT_BITS       = 5;
  localparam int DIGIT_BITS_DEF   = 8;
  localparam int DIVISOR_BITS_DEF = 16;

  localparam logic [1:0] REG_RADIX          = 2'd0;
  localparam logic [1:0] REG_DIVISOR_VALUE  = 2'd1;
  localparam logic [1:0] REG_DIVISOR_DIGITS = 2'd2;

  localparam int RADIX_RST          = 10;
  localparam int DIVISOR_VALUE_RST  = 1;
  localparam int DIVISOR_DIGITS_RST = 1;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- design/rnsd_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rnsd_pkg for the status struct.
`default_nettype none

module rnsd_divider #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [DIVIDEND_BITS-1:0]   dividend,
  input  wire [DIVISOR_BITS-1:0]    divisor,
  output rnsd_pkg::div_stat_t       stat,
  output logic [DIVIDEND_BITS-1:0]  quotient,
  output logic [DIVISOR_BITS-1:0]   remainder
);
  import rnsd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    trial;
  logic                     fits;

  // Dividend bits shift out of the top of quo_r while quotient bits enter below.
  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIVIDEND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DIVISOR_BITS'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DIVISOR_BITS-1:0];
      end
      quo_nxt = {quo_r[DIVIDEND_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- design/radix_n_short_divider_core.sv -----
// Radix-N short divider with one request in flight. A warm-up digit passes through
// ST_IDLE and ST_MUL; an ending short dividend or a zero divisor also passes ST_FIN,
// and a divide also waits in ST_DIV for the bit-serial divider before ST_FIN.
// A new digit is taken only in ST_IDLE; an untaken result stalls the next one.
// rst_n is synchronous and active low; it restores radix 10, divisor 1,
// divisor length 1 and clears the running value and digit count.
`default_nettype none

module radix_n_short_divider_core #(
  parameter int DIGIT_BITS   = rnsd_pkg::DIGIT_BITS_DEF,
  parameter int DIVISOR_BITS = rnsd_pkg::DIVISOR_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Dividend digit channel.
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [DIGIT_BITS-1:0]         in_digit,
  input  wire                          in_last_in,
  // Quotient digit channel.
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [DIGIT_BITS-1:0]        out_quotient_digit,
  output logic                         out_last_out,
  // Register port.
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [rnsd_pkg::ADDR_W-1:0]   paddr,
  input  wire [rnsd_pkg::DATA_W-1:0]   pwdata,
  output logic [rnsd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import rnsd_pkg::*;

  localparam int RADIX_BITS = DIGIT_BITS + 1;
  localparam int RV_BITS    = DIVISOR_BITS + DIGIT_BITS;
  localparam int PROD_BITS  = RV_BITS + RADIX_BITS;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers.
  logic [RADIX_BITS-1:0]   radix_r;
  logic [DIVISOR_BITS-1:0] divisor_value_r;
  logic [COUNT_BITS-1:0]   divisor_digits_r;
  logic                    wr_en;
  logic [1:0]              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r          <= RADIX_BITS'(RADIX_RST);
      divisor_value_r  <= DIVISOR_BITS'(DIVISOR_VALUE_RST);
      divisor_digits_r <= COUNT_BITS'(DIVISOR_DIGITS_RST);
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIX:          radix_r          <= pwdata[RADIX_BITS-1:0];
        REG_DIVISOR_VALUE:  divisor_value_r  <= pwdata[DIVISOR_BITS-1:0];
        REG_DIVISOR_DIGITS: divisor_digits_r <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:          prdata = DATA_W'(radix_r);
      REG_DIVISOR_VALUE:  prdata = DATA_W'(divisor_value_r);
      REG_DIVISOR_DIGITS: prdata = DATA_W'(divisor_digits_r);
      default:            prdata = '0;
    endcase
  end

  // Datapath and sequencer state.
  logic [1:0]              state_r, state_nxt;
  logic [DIGIT_BITS-1:0]   digit_r, digit_nxt;
  logic                    last_r, last_nxt;
  logic [RV_BITS-1:0]      rv_r, rv_nxt;
  logic [COUNT_BITS-1:0]   seen_r, seen_nxt;
  logic [DIGIT_BITS-1:0]   res_q_r, res_q_nxt;
  logic                    res_last_r, res_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [DIGIT_BITS-1:0]   out_q_r, out_q_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [PROD_BITS-1:0]    prod;
  logic [RV_BITS-1:0]      rv_fold;
  logic [COUNT_BITS-1:0]   target;
  logic [COUNT_BITS-1:0]   seen_inc;
  logic                    div_start;
  div_stat_t               div_stat;
  logic [RV_BITS-1:0]      div_quo;
  logic [DIVISOR_BITS-1:0] div_rem;
  logic                    slot_free;

  // Fold the new digit into the running value; this is the only multiplier.
  assign prod    = PROD_BITS'(rv_r) * PROD_BITS'(radix_r);
  assign rv_fold = prod[RV_BITS-1:0] + RV_BITS'(digit_r);

  // A divisor length of zero counts as one digit.
  assign target   = (divisor_digits_r == '0) ? COUNT_BITS'(1) : divisor_digits_r;
  assign seen_inc = (seen_r < target) ? (seen_r + 1'b1) : seen_r;

  // The result register may be reloaded when empty or when it is being taken.
  assign slot_free = !out_valid_r || out_ready;

  rnsd_divider #(
    .DIVIDEND_BITS (RV_BITS),
    .DIVISOR_BITS  (DIVISOR_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rv_fold),
    .divisor   (divisor_value_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    rv_nxt        = rv_r;
    seen_nxt      = seen_r;
    res_q_nxt     = res_q_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r;
    out_q_nxt     = out_q_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          digit_nxt = in_digit;
          last_nxt  = in_last_in;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        seen_nxt = seen_inc;
        if (seen_inc < target) begin
          // Warm-up digit, or a dividend shorter than the divisor.
          if (last_r) begin
            rv_nxt       = '0;
            seen_nxt     = '0;
            res_q_nxt    = '0;
            res_last_nxt = 1'b1;
            state_nxt    = ST_FIN;
          end else begin
            rv_nxt    = rv_fold;
            state_nxt = ST_IDLE;
          end
        end else if (divisor_value_r == '0) begin
          // A zero divisor gives an all-ones quotient and keeps the value unless last.
          rv_nxt       = last_r ? '0 : rv_fold;
          res_q_nxt    = '1;
          res_last_nxt = last_r;
          if (last_r) begin
            seen_nxt = '0;
          end
          state_nxt = ST_FIN;
        end else begin
          div_start    = 1'b1;
          res_last_nxt = last_r;
          if (last_r) begin
            seen_nxt = '0;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // Quotients that do not fit in one digit saturate.
          if (|div_quo[RV_BITS-1:DIGIT_BITS]) begin
            res_q_nxt = '1;
          end else begin
            res_q_nxt = div_quo[DIGIT_BITS-1:0];
          end
          rv_nxt    = res_last_r ? '0 : RV_BITS'(div_rem);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = res_q_r;
          out_last_nxt  = res_last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    digit_r    <= digit_nxt;
    last_r     <= last_nxt;
    res_q_r    <= res_q_nxt;
    res_last_r <= res_last_nxt;
    out_q_r    <= out_q_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_quotient_digit = out_q_r;
  assign out_last_out       = out_last_r;

endmodule

`default_nettype wire
